[design/psi_pkg.sv]
// Package for the parameter slide interpolator.
// Holds the lane entry layout, fixed-point constants and divider request and response structs; no dependencies.
package psi_pkg;

  // Round-half constant and fraction width of the 8.8 accumulator.
  localparam logic [15:0] ROUND_HALF = 16'd128;
  localparam int          FRAC_BITS  = 8;
  localparam int          LANE_SLOTS = 8;
  localparam logic        KIND_ARM   = 1'b0;
  localparam logic        KIND_TICK  = 1'b1;

  // One lane of slide state as it sits in the lane memory.
  typedef struct packed {
    logic [15:0] pos_tick;
    logic [15:0] end_tick;
    logic [7:0]  base_value;
    logic [7:0]  final_value;
    logic [15:0] accumulator;
    logic [15:0] slope;
    logic [7:0]  lane_code;
  } lane_entry_t;

  // Control and result lines between the top level and the slope divider.
  typedef struct packed {
    logic        start;
    logic [16:0] dividend;
    logic [15:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [15:0] quotient;
  } div_rsp_t;

endpackage

[design/psi_div.sv]
// Iterative signed-by-unsigned divider for the slide slope, one bit a cycle.
// Depends on psi_pkg for the request and response structs.
module psi_div import psi_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic [15:0] rem;
  logic [15:0] qm;
  logic [15:0] den;
  logic        neg;
  logic [4:0]  count;
  logic        running;
  logic        done;
  logic [16:0] trial;
  logic        fits;
  logic [16:0] mag_in;

  // Magnitude of the signed dividend; it never exceeds 16 bits.
  assign mag_in = req.dividend[16] ? (17'd0 - req.dividend) : req.dividend;

  // Shift in the next dividend bit and try to subtract the divisor.
  assign trial = {rem, qm[15]};
  assign fits  = trial >= {1'b0, den};

  // Control: count sixteen iterations, then pulse done.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      count   <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        running <= 1'b1;
        count   <= 5'd0;
      end else if (running) begin
        count <= count + 5'd1;
        if (count == 5'd15) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and quotient shift register.
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem <= 16'd0;
      qm  <= mag_in[15:0];
      den <= req.divisor;
      neg <= req.dividend[16];
    end else if (running) begin
      rem <= fits ? 16'(trial - {1'b0, den}) : trial[15:0];
      qm  <= {qm[14:0], fits};
    end
  end

  // Truncation toward zero: negate the magnitude quotient for a negative dividend.
  assign rsp.done     = done;
  assign rsp.quotient = neg ? (16'd0 - qm) : qm;

endmodule

[design/parameter_slide_interpolator_top.sv]
// Parameter slide interpolator: multi-lane linear glide generator.
// Depends on psi_pkg and instantiates the slope divider psi_div.
//
// Usage:
//   A request is taken at a rising edge where start is high and busy is low.
//   kind = 0 arms lane `lane` with a slide; kind = 1 is one clock tick.
//   An arm request emits nothing. With a non-empty slide the bit-serial slope
//   divider runs and the lane is written back when it is done; an empty slide
//   is written directly and an out-of-range lane is dropped; neither raises busy.
//   A tick request walks the lanes in index order through the lane memory,
//   one lane read per cycle with the read-modify-write in the cycle after
//   each read; lanes past eight do not exist.
//   Each active lane yields one result on lane_index, param_number, value and
//   last, shown for exactly one cycle while valid is high; last marks the final
//   result of the tick. Results are held back one lane so that last is known,
//   so the first result appears only once a later active lane has been read or
//   the walk has ended, and the last one in the cycle after the walk ends.
//   The receiver cannot stall; results are never held off.
//   Reset clears all control state and the per-lane valid bits, so every lane
//   reads as empty (all zero) until it is armed. No clearing pass is needed.
module parameter_slide_interpolator_top import psi_pkg::*; #(
  parameter int NUM_LANES = 8
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        kind,
  input  logic [2:0]  lane,
  input  logic [15:0] start_tick,
  input  logic [15:0] end_tick,
  input  logic [7:0]  start_value,
  input  logic [7:0]  end_value,
  input  logic [7:0]  param_code,
  output logic        valid,
  output logic [2:0]  lane_index,
  output logic [7:0]  param_number,
  output logic [7:0]  value,
  output logic        last
);

  localparam int LANES = (NUM_LANES < LANE_SLOTS) ? NUM_LANES : LANE_SLOTS;
  localparam int LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam int SW    = $clog2(LANES + 1);

  typedef enum logic [1:0] {ST_IDLE, ST_DIV, ST_TICK} state_t;

  state_t      state;
  logic [SW-1:0] step;
  logic        s1_vld;
  logic [LW-1:0] s1_idx;

  // Lane memory, its read register and the per-lane valid bits.
  lane_entry_t mem [LANES];
  lane_entry_t rd_data;
  logic        rd_vld;
  logic [LANES-1:0] vld;
  logic [LW-1:0] rd_addr;
  logic        wr_en;
  logic [LW-1:0] wr_addr;
  lane_entry_t wr_data;

  // Latched arm request while the divider runs.
  lane_entry_t arm_entry;
  logic [LW-1:0] arm_lane;

  // Pending result, held until the next one or the end of the walk.
  logic        pend_vld;
  logic [2:0]  pend_lane;
  logic [7:0]  pend_param;
  logic [7:0]  pend_value;
  logic        emit;

  div_req_t    dreq;
  div_rsp_t    drsp;

  logic        accept;
  logic        lane_ok;
  logic [16:0] tick_diff;
  logic        steps_pos;
  logic [8:0]  value_diff;
  lane_entry_t arm_in;

  lane_entry_t cur;
  logic        act;
  logic [15:0] rounded;
  logic [7:0]  ramp_value;
  logic [15:0] acc_next;
  logic [15:0] pos_next;
  logic        fin;
  lane_entry_t upd;
  logic        walk_done;

  psi_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  assign busy   = (state != ST_IDLE);
  assign accept = start && !busy;

  // Arm decode: lane range, tick span and the scaled value difference.
  assign lane_ok    = {1'b0, lane} < 4'(LANES);
  assign tick_diff  = {end_tick[15], end_tick} - {start_tick[15], start_tick};
  assign steps_pos  = !tick_diff[16] && (tick_diff != 17'd0);
  assign value_diff = {end_value[7], end_value} - {start_value[7], start_value};

  assign dreq.start    = accept && (kind == KIND_ARM) && lane_ok && steps_pos;
  assign dreq.dividend = {value_diff, 8'd0};
  assign dreq.divisor  = tick_diff[15:0];

  always_comb begin
    arm_in             = '0;
    arm_in.pos_tick    = start_tick;
    arm_in.end_tick    = end_tick;
    arm_in.base_value  = start_value;
    arm_in.final_value = end_value;
    arm_in.lane_code   = param_code;
  end

  // Lane step: rounded value, accumulator advance and final-tick check.
  assign cur        = rd_vld ? rd_data : '0;
  assign act        = (cur.lane_code != 8'd0) &&
                      ($signed(cur.pos_tick) < $signed(cur.end_tick));
  assign rounded    = cur.accumulator + ROUND_HALF;
  assign ramp_value = cur.base_value + rounded[15:FRAC_BITS];
  assign acc_next   = cur.accumulator + cur.slope;
  assign pos_next   = cur.pos_tick + 16'd1;
  assign fin        = !($signed(pos_next) < $signed(cur.end_tick));

  always_comb begin
    upd = cur;
    upd.accumulator = acc_next;
    upd.pos_tick    = pos_next;
    if (fin) begin
      upd           = '0;
      upd.lane_code = cur.lane_code;
    end
  end

  assign walk_done = (state == ST_TICK) && (step == SW'(LANES)) && !s1_vld;

  // The pending result goes out when a newer one replaces it or the walk ends.
  assign emit = pend_vld && ((s1_vld && act) || walk_done);

  // Memory address and write port selection.
  assign rd_addr = step[LW-1:0];

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = arm_lane;
    wr_data = arm_entry;
    if (state == ST_IDLE) begin
      wr_en   = accept && (kind == KIND_ARM) && lane_ok && !steps_pos;
      wr_addr = lane[LW-1:0];
      wr_data = arm_in;
    end else if (state == ST_DIV) begin
      wr_en         = drsp.done;
      wr_data.slope = drsp.quotient;
    end else if (state == ST_TICK) begin
      wr_en   = s1_vld && act;
      wr_addr = s1_idx;
      wr_data = upd;
    end
  end

  // Lane memory: one write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

  // Valid bits: a lane never written reads as all zero.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      rd_vld <= 1'b0;
    end else begin
      if (wr_en) begin
        vld[wr_addr] <= 1'b1;
      end
      rd_vld <= vld[rd_addr];
    end
  end

  // Sequencer with the pending result buffer and registered outputs.
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      step     <= '0;
      s1_vld   <= 1'b0;
      s1_idx   <= '0;
      pend_vld <= 1'b0;
      valid    <= 1'b0;
      last     <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          valid <= 1'b0;
          last  <= 1'b0;
          if (accept) begin
            if (kind == KIND_TICK) begin
              state    <= ST_TICK;
              step     <= '0;
              s1_vld   <= 1'b0;
              pend_vld <= 1'b0;
            end else if (dreq.start) begin
              state     <= ST_DIV;
              arm_entry <= arm_in;
              arm_lane  <= lane[LW-1:0];
            end
          end
        end
        ST_DIV: begin
          valid <= 1'b0;
          last  <= 1'b0;
          if (drsp.done) begin
            state <= ST_IDLE;
          end
        end
        ST_TICK: begin
          s1_vld <= step < SW'(LANES);
          s1_idx <= step[LW-1:0];
          if (step < SW'(LANES)) begin
            step <= step + SW'(1);
          end
          valid <= emit;
          last  <= pend_vld && walk_done;
          if (emit) begin
            lane_index   <= pend_lane;
            param_number <= pend_param;
            value        <= pend_value;
          end
          if (s1_vld && act) begin
            pend_vld   <= 1'b1;
            pend_lane  <= 3'(s1_idx);
            pend_param <= cur.lane_code - 8'd1;
            pend_value <= fin ? cur.final_value : ramp_value;
          end
          if (walk_done) begin
            state    <= ST_IDLE;
            pend_vld <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
          valid <= 1'b0;
          last  <= 1'b0;
        end
      endcase
    end
  end

endmodule

[design/psi_checker.sv]
// Port-level checker for the parameter slide interpolator, bound to the top.
// Depends only on the top level's ports.
module psi_checker (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        kind,
  input logic        valid,
  input logic        last
);

  // After the last result of a tick, no result follows in the next cycle.
  a_last_gap: assert property (@(posedge clk) disable iff (rst)
    valid && last |=> !valid)
    else $error("result right after the last result of a tick");

  // An arm request never produces a result.
  a_arm_silent: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !kind |=> !valid)
    else $error("result after an arm request");

  // A result that is not the last comes while the tick walk is still running.
  a_mid_busy: assert property (@(posedge clk) disable iff (rst)
    valid && !last |-> busy)
    else $error("non-final result while idle");

  // A tick request always starts a lane walk.
  a_tick_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && kind |=> busy)
    else $error("tick request did not start a walk");

endmodule

bind parameter_slide_interpolator_top psi_checker u_psi_checker (
  .clk   (clk),
  .rst   (rst),
  .start (start),
  .busy  (busy),
  .kind  (kind),
  .valid (valid),
  .last  (last)
);
